### rtl/core/ttup_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttup_pkg: shared types and constants of the text to unsigned parser
// Parse phases, character codes, radix constants and the digit decoder.
// ----------------------------------------------------------------------------
package ttup_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OFFSET_BITS = 16;
  localparam int BASE_BITS   = 6;
  localparam int CHAR_BITS   = 8;

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_BITS-1:0] NOT_DIGIT = 6'd36;
  localparam logic [BASE_BITS-1:0] ALPHA_OFS = 6'd10;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] offset;
    logic [BASE_BITS-1:0]   base;
    logic                   done;
  } result_t;

  // Value of an alphanumeric character, NOT_DIGIT for anything else.
  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] diff;
    logic [BASE_BITS-1:0] val;
    begin
      diff = '0;
      val  = NOT_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        diff = c - CH_ZERO;
        val  = diff[BASE_BITS-1:0];
      end else if (c >= CH_LA && c <= CH_LZ) begin
        diff = c - CH_LA;
        val  = diff[BASE_BITS-1:0] + ALPHA_OFS;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        diff = c - CH_UA;
        val  = diff[BASE_BITS-1:0] + ALPHA_OFS;
      end
      return val;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/text_to_unsigned_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_unsigned_parser: streaming unsigned integer parser
// Parses one character per request and reports the running value, offset,
// radix and completion flag of the current string.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while in_stall_o is low and
// returns one result per character, registered in the output buffer. The rate is
// set by the per-character multiply-accumulate (value times radix plus digit),
// which is computed combinationally together with the parse state update. A
// two-entry output buffer lets requests keep flowing while a result waits;
// in_stall_o rises only when both entries are full. Set start_flag_i on the
// first character of every string. number_base is sampled at the first
// non-space character, so a new setting acts from the next string on.
module text_to_unsigned_parser (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ttup_pkg::BASE_BITS-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                start_flag_i,
  input  wire logic [ttup_pkg::CHAR_BITS-1:0]      char_byte_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [ttup_pkg::VALUE_BITS-1:0]          parsed_value_o,
  output logic [ttup_pkg::OFFSET_BITS-1:0]         end_offset_o,
  output logic [ttup_pkg::BASE_BITS-1:0]           base_in_use_o,
  output logic                                     parse_done_o
);

  logic [ttup_pkg::BASE_BITS-1:0]   number_base_q;
  ttup_pkg::phase_e                 phase_q, phase_d, phase_cur;
  logic [ttup_pkg::BASE_BITS-1:0]   base_q, base_d, base_cur;
  logic [ttup_pkg::VALUE_BITS-1:0]  acc_q, acc_d, acc_cur;
  logic [ttup_pkg::OFFSET_BITS-1:0] cnt_q, cnt_d, cnt_cur;

  logic [ttup_pkg::BASE_BITS-1:0]   digit;
  logic [ttup_pkg::BASE_BITS-1:0]   take_base;
  logic                             is_space, is_zero, is_x;
  logic                             take, digit_ok, bump;

  ttup_pkg::result_t                res_new, main_q, skid_q;
  logic                             main_vld_q, skid_vld_q;
  logic                             push, pop;

  assign push = in_valid_i & ~in_stall_o;
  assign pop  = out_valid_o & ~out_stall_i;

  // A start flag clears the state before the character is looked at.
  assign phase_cur = start_flag_i ? ttup_pkg::PH_SKIP : phase_q;
  assign base_cur  = start_flag_i ? ttup_pkg::BASE_AUTO : base_q;
  assign acc_cur   = start_flag_i ? '0 : acc_q;
  assign cnt_cur   = start_flag_i ? '0 : cnt_q;

  assign digit    = ttup_pkg::digit_of(char_byte_i);
  assign is_space = (char_byte_i == ttup_pkg::CH_SPACE);
  assign is_zero  = (char_byte_i == ttup_pkg::CH_ZERO);
  assign is_x     = (char_byte_i == ttup_pkg::CH_LX) || (char_byte_i == ttup_pkg::CH_UX);

  // Radix that applies to this character if it is taken as a digit.
  always_comb begin
    unique case (phase_cur)
      ttup_pkg::PH_SKIP:
        take_base = (number_base_q != ttup_pkg::BASE_AUTO) ? number_base_q
                                                            : ttup_pkg::BASE_DEC;
      ttup_pkg::PH_ZERO: take_base = ttup_pkg::BASE_OCT;
      default:           take_base = base_cur;
    endcase
  end

  assign take = ((phase_cur == ttup_pkg::PH_SKIP) && !is_space &&
                 ((number_base_q != ttup_pkg::BASE_AUTO) || !is_zero)) ||
                ((phase_cur == ttup_pkg::PH_ZERO) && !is_x) ||
                (phase_cur == ttup_pkg::PH_DIGITS);
  assign digit_ok = (digit != ttup_pkg::NOT_DIGIT) && (digit < take_base);

  // Next parse phase.
  always_comb begin
    phase_d = phase_cur;
    if (take) begin
      phase_d = digit_ok ? ttup_pkg::PH_DIGITS : ttup_pkg::PH_DONE;
    end else begin
      unique case (phase_cur)
        ttup_pkg::PH_SKIP: phase_d = is_space ? ttup_pkg::PH_SKIP : ttup_pkg::PH_ZERO;
        ttup_pkg::PH_ZERO: phase_d = ttup_pkg::PH_DIGITS;
        default:           phase_d = phase_cur;
      endcase
    end
  end

  // Datapath: radix, accumulator and consumed character count.
  always_comb begin
    base_d = base_cur;
    unique case (phase_cur)
      ttup_pkg::PH_SKIP: begin
        if (!is_space && (number_base_q != ttup_pkg::BASE_AUTO || !is_zero)) begin
          base_d = take_base;
        end
      end
      ttup_pkg::PH_ZERO: base_d = is_x ? ttup_pkg::BASE_HEX : ttup_pkg::BASE_OCT;
      default:           base_d = base_cur;
    endcase

    acc_d = acc_cur;
    if (take && digit_ok) begin
      acc_d = ttup_pkg::VALUE_BITS'(acc_cur * ttup_pkg::VALUE_BITS'(take_base)) +
              ttup_pkg::VALUE_BITS'(digit);
    end

    // Prefix characters and skipped spaces count as consumed too.
    bump = (take && digit_ok) ||
           (!take && (phase_cur == ttup_pkg::PH_SKIP)) ||
           (!take && (phase_cur == ttup_pkg::PH_ZERO));
    cnt_d = cnt_cur;
    if (bump && (cnt_cur != ttup_pkg::OFFSET_MAX)) begin
      cnt_d = cnt_cur + 1'b1;
    end
  end

  assign res_new.value  = acc_d;
  assign res_new.offset = cnt_d;
  assign res_new.base   = base_d;
  assign res_new.done   = (phase_d == ttup_pkg::PH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= ttup_pkg::BASE_AUTO;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ttup_pkg::PH_SKIP;
      base_q  <= ttup_pkg::BASE_AUTO;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (push) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output buffer: the main entry drives the ports, the skid entry catches a
  // result produced while the main entry is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !main_vld_q) begin
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        main_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_vld_q) begin
      main_q <= skid_vld_q ? skid_q : res_new;
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign in_stall_o     = skid_vld_q;
  assign out_valid_o    = main_vld_q;
  assign parsed_value_o = main_q.value;
  assign end_offset_o   = main_q.offset;
  assign base_in_use_o  = main_q.base;
  assign parse_done_o   = main_q.done;

endmodule
`default_nettype wire

### rtl/core/ttup_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttup_checker: port-level checks for the text to unsigned parser
// Watches the request and result channels and the output buffer behavior.
// ----------------------------------------------------------------------------
module ttup_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic [ttup_pkg::VALUE_BITS-1:0]     parsed_value_o,
  input wire logic [ttup_pkg::OFFSET_BITS-1:0]    end_offset_o,
  input wire logic [ttup_pkg::BASE_BITS-1:0]      base_in_use_o,
  input wire logic                                parse_done_o
);

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(parsed_value_o) &&
      $stable(end_offset_o) && $stable(base_in_use_o) && $stable(parse_done_o))
    else $error("stalled result changed");

  // Input stall means both buffer entries are full, so a result is waiting.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A request into an empty buffer shows up as a result on the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // A full buffer cannot drain while the result side stalls.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i |=> in_stall_o)
    else $error("buffer entry lost under stall");

endmodule

bind text_to_unsigned_parser ttup_checker u_ttup_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .parsed_value_o (parsed_value_o),
  .end_offset_o   (end_offset_o),
  .base_in_use_o  (base_in_use_o),
  .parse_done_o   (parse_done_o)
);
`default_nettype wire

### dv/tb_text_to_unsigned_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_to_unsigned_parser: self-checking bench for the streaming parser
// A short table of directed strings covers prefixes, terminators, base latch
// and odd radixes. Random strings follow in phases with different radix
// settings. Every result is compared field by field against a typed-in result
// or a cycle-free parser model.
// ----------------------------------------------------------------------------
module tb_text_to_unsigned_parser;

  localparam int WD_LIMIT   = 2000;
  localparam int N_DIR      = 30;
  localparam int N_PHASES   = 12;
  localparam int PHASE_LEN  = 160;

  localparam logic [ttup_pkg::BASE_BITS-1:0] B_AUTO = ttup_pkg::BASE_AUTO;
  localparam logic [ttup_pkg::BASE_BITS-1:0] B_DEC  = ttup_pkg::BASE_DEC;
  localparam logic [ttup_pkg::BASE_BITS-1:0] B_OCT  = ttup_pkg::BASE_OCT;
  localparam logic [ttup_pkg::BASE_BITS-1:0] B_HEX  = ttup_pkg::BASE_HEX;
  localparam logic [ttup_pkg::CHAR_BITS-1:0] C_NUL  = ttup_pkg::CH_NUL;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [ttup_pkg::BASE_BITS-1:0] base;
    logic                           st;
    logic [ttup_pkg::CHAR_BITS-1:0] ch;
    logic                           known;
    ttup_pkg::result_t              res;
  } dir_row_t;

  // Rows with known = 1 carry the result typed in; the rest use the model.
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{ROW_CHAR, B_AUTO, 1'b0, "7",    1'b1, '{32'd7, 16'd1, B_DEC, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, C_NUL,  1'b1, '{32'd7, 16'd1, B_DEC, 1'b1}},
    '{ROW_CHAR, B_AUTO, 1'b0, "x",    1'b1, '{32'd7, 16'd1, B_DEC, 1'b1}},
    '{ROW_CHAR, B_AUTO, 1'b1, "0",    1'b1, '{32'd0, 16'd1, B_AUTO, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "x",    1'b1, '{32'd0, 16'd2, B_HEX, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, C_NUL,  1'b1, '{32'd0, 16'd2, B_HEX, 1'b1}},
    '{ROW_CHAR, B_AUTO, 1'b1, " ",    1'b1, '{32'd0, 16'd1, B_AUTO, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "0",    1'b1, '{32'd0, 16'd2, B_AUTO, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "7",    1'b1, '{32'd7, 16'd3, B_OCT, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "8",    1'b1, '{32'd7, 16'd3, B_OCT, 1'b1}},
    '{ROW_CHAR, B_AUTO, 1'b1, "0",    1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b0, "X",    1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b0, "f",    1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b0, "g",    1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b1, C_NUL,  1'b1, '{32'd0, 16'd0, B_DEC, 1'b1}},
    '{ROW_CHAR, B_AUTO, 1'b1, 8'hFF,  1'b1, '{32'd0, 16'd0, B_DEC, 1'b1}},
    '{ROW_CFG,  B_HEX,  1'b0, C_NUL,  1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b1, "0",    1'b1, '{32'd0, 16'd1, B_HEX, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "x",    1'b1, '{32'd0, 16'd1, B_HEX, 1'b1}},
    '{ROW_CFG,  6'd1,   1'b0, C_NUL,  1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b1, "0",    1'b1, '{32'd0, 16'd1, 6'd1, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "1",    1'b1, '{32'd0, 16'd1, 6'd1, 1'b1}},
    '{ROW_CFG,  6'd63,  1'b0, C_NUL,  1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b1, "Z",    1'b1, '{32'd35, 16'd1, 6'd63, 1'b0}},
    '{ROW_CHAR, B_AUTO, 1'b0, "z",    1'b0, '0},
    '{ROW_CFG,  6'd36,  1'b0, C_NUL,  1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b1, "z",    1'b1, '{32'd35, 16'd1, 6'd36, 1'b0}},
    '{ROW_CFG,  6'd2,   1'b0, C_NUL,  1'b0, '0},
    '{ROW_CHAR, B_AUTO, 1'b0, "z",    1'b1, '{32'd1295, 16'd2, 6'd36, 1'b0}},
    '{ROW_CFG,  B_AUTO, 1'b0, C_NUL,  1'b0, '0}
  };

  localparam logic [ttup_pkg::BASE_BITS-1:0] PHASE_BASES [N_PHASES] = '{
    B_AUTO, B_DEC, B_HEX, B_OCT, 6'd2, 6'd36,
    6'd63, 6'd1, B_AUTO, 6'd37, 6'd5, B_AUTO
  };

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             cfg_we_i     = 1'b0;
  logic [ttup_pkg::BASE_BITS-1:0]   cfg_wdata_i  = '0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic                             start_flag_i = 1'b0;
  logic [ttup_pkg::CHAR_BITS-1:0]   char_byte_i  = '0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic [ttup_pkg::VALUE_BITS-1:0]  parsed_value_o;
  logic [ttup_pkg::OFFSET_BITS-1:0] end_offset_o;
  logic [ttup_pkg::BASE_BITS-1:0]   base_in_use_o;
  logic                             parse_done_o;

  // Typed-in expectation that travels with the current request.
  logic              req_known = 1'b0;
  ttup_pkg::result_t req_res   = '0;

  int   gap_pct     = 0;
  int   stall_pct   = 0;
  bit   quiet       = 1'b0;
  int   stall_left  = 0;
  int   idle_cycles = 0;
  int   mismatches  = 0;
  int   items_sent  = 0;
  logic [ttup_pkg::BASE_BITS-1:0] cur_base = B_AUTO;

  // Parser model state.
  logic [ttup_pkg::BASE_BITS-1:0]   cfg_radix_m = B_AUTO;
  ttup_pkg::phase_e                 phase_m     = ttup_pkg::PH_SKIP;
  logic [ttup_pkg::BASE_BITS-1:0]   radix_m     = '0;
  logic [ttup_pkg::VALUE_BITS-1:0]  acc_m       = '0;
  logic [ttup_pkg::OFFSET_BITS-1:0] count_m     = '0;

  ttup_pkg::result_t pending_results [$];

  text_to_unsigned_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_flag_i   (start_flag_i),
    .char_byte_i    (char_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .parsed_value_o (parsed_value_o),
    .end_offset_o   (end_offset_o),
    .base_in_use_o  (base_in_use_o),
    .parse_done_o   (parse_done_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int char_value(input logic [ttup_pkg::CHAR_BITS-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
    return int'(ttup_pkg::NOT_DIGIT);
  endfunction

  function automatic void count_char();
    if (count_m != ttup_pkg::OFFSET_MAX) count_m = count_m + 1'b1;
  endfunction

  function automatic void take_char(input logic [ttup_pkg::CHAR_BITS-1:0] c);
    int d;
    d = char_value(c);
    if (d == int'(ttup_pkg::NOT_DIGIT) || d >= int'(radix_m)) begin
      phase_m = ttup_pkg::PH_DONE;
    end else begin
      acc_m = acc_m * ttup_pkg::VALUE_BITS'(radix_m) + ttup_pkg::VALUE_BITS'(d);
      count_char();
      phase_m = ttup_pkg::PH_DIGITS;
    end
  endfunction

  function automatic ttup_pkg::result_t parse_char(input logic st,
                                                   input logic [ttup_pkg::CHAR_BITS-1:0] c);
    if (st) begin
      phase_m = ttup_pkg::PH_SKIP;
      radix_m = '0;
      acc_m   = '0;
      count_m = '0;
    end
    case (phase_m)
      ttup_pkg::PH_SKIP: begin
        if (c == ttup_pkg::CH_SPACE) begin
          count_char();
        end else if (cfg_radix_m != B_AUTO) begin
          radix_m = cfg_radix_m;
          take_char(c);
        end else if (c == ttup_pkg::CH_ZERO) begin
          count_char();
          phase_m = ttup_pkg::PH_ZERO;
        end else begin
          radix_m = B_DEC;
          take_char(c);
        end
      end
      ttup_pkg::PH_ZERO: begin
        if (c == ttup_pkg::CH_LX || c == ttup_pkg::CH_UX) begin
          radix_m = B_HEX;
          count_char();
          phase_m = ttup_pkg::PH_DIGITS;
        end else begin
          radix_m = B_OCT;
          take_char(c);
        end
      end
      ttup_pkg::PH_DIGITS: take_char(c);
      default: ;
    endcase
    return '{acc_m, count_m, radix_m, phase_m == ttup_pkg::PH_DONE};
  endfunction

  task automatic report(input string what, input ttup_pkg::result_t want,
                        input ttup_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected value=%h offset=%0d base=%0d done=%b, %s",
               $time, what, want.value, want.offset, want.base, want.done,
               $sformatf("got value=%h offset=%0d base=%0d done=%b",
                         got.value, got.offset, got.base, got.done));
  endtask

  // Model update, result checking and the watchdog all follow the clock edge.
  always @(posedge clk_i) begin : scoreboard
    ttup_pkg::result_t want;
    ttup_pkg::result_t got;
    logic              in_acc;
    logic              out_acc;
    in_acc  = rst_ni && in_valid_i && !in_stall_o;
    out_acc = rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && cfg_we_i) cfg_radix_m = cfg_wdata_i;
    if (in_acc) begin
      want = parse_char(start_flag_i, char_byte_i);
      if (req_known) want = req_res;
      pending_results.push_back(want);
    end
    if (out_acc) begin
      got = '{parsed_value_o, end_offset_o, base_in_use_o, parse_done_o};
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.offset !== want.offset ||
            got.base !== want.base || got.done !== want.done)
          report("result mismatch", want, got);
      end
    end
    if (rst_ni) begin
      if (in_acc || out_acc) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles", $time, WD_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Output stall comes in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(99) < stall_pct) begin
      stall_left  <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_char(input logic st, input logic [ttup_pkg::CHAR_BITS-1:0] c,
                           input logic known, input ttup_pkg::result_t res);
    int gap;
    if (!quiet && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_flag_i <= st;
    char_byte_i  <= c;
    req_known    <= known;
    req_res      <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic emit(inout bit st, input logic [ttup_pkg::CHAR_BITS-1:0] c);
    send_char(st, c, 1'b0, '0);
    st = 1'b0;
  endtask

  // Returns once every accepted request has produced its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [ttup_pkg::BASE_BITS-1:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_base = b;
  endtask

  function automatic logic [ttup_pkg::CHAR_BITS-1:0] digit_char(input int v);
    if (v < 10) return ttup_pkg::CHAR_BITS'(int'("0") + v);
    if ($urandom_range(1)) return ttup_pkg::CHAR_BITS'(int'("a") + v - 10);
    return ttup_pkg::CHAR_BITS'(int'("A") + v - 10);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 30;
    endcase
  endfunction

  // A well-formed number: spaces, optional prefix, digits, a terminator and
  // sometimes trailing characters that the parser must ignore.
  task automatic gen_number();
    bit st;
    int eff;
    int n;
    st = 1'b1;
    n = $urandom_range(0, 3);
    repeat (n) emit(st, ttup_pkg::CH_SPACE);
    if (cur_base == B_AUTO) begin
      case ($urandom_range(0, 3))
        0: eff = 10;
        1: begin
          eff = 8;
          emit(st, ttup_pkg::CH_ZERO);
        end
        default: begin
          eff = 16;
          emit(st, ttup_pkg::CH_ZERO);
          emit(st, $urandom_range(1) ? ttup_pkg::CH_LX : ttup_pkg::CH_UX);
        end
      endcase
    end else begin
      eff = (cur_base > 36) ? 36 : int'(cur_base);
      if (cur_base == B_HEX && $urandom_range(7) == 0) begin
        emit(st, ttup_pkg::CH_ZERO);
        emit(st, ttup_pkg::CH_LX);
      end
    end
    n = $urandom_range(0, 12);
    repeat (n) emit(st, digit_char($urandom_range(0, eff - 1)));
    case ($urandom_range(0, 2))
      0: emit(st, C_NUL);
      1: emit(st, ttup_pkg::CHAR_BITS'($urandom_range(0, 255)));
      default: emit(st, (eff < 36) ? digit_char($urandom_range(eff, 35)) : C_NUL);
    endcase
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) emit(st, ttup_pkg::CHAR_BITS'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_char($urandom_range(3) == 0,
                         ttup_pkg::CHAR_BITS'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  initial begin : stimulus
    dir_row_t row;
    int       target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 10;
    stall_pct = 10;
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_base(row.base);
      end else begin
        send_char(row.st, row.ch, row.known, row.res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_base((p == 10) ? ttup_pkg::BASE_BITS'($urandom_range(0, 63)) : PHASE_BASES[p]);
      quiet     = (p == N_PHASES - 1);
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      target    = items_sent + PHASE_LEN;
      while (items_sent < target) begin
        if ($urandom_range(99) < 85) gen_number();
        else gen_noise();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ttup_pkg.sv
rtl/core/text_to_unsigned_parser.sv
rtl/core/ttup_checker.sv
dv/tb_text_to_unsigned_parser.sv
